// ----- hw/rtl/wsjd_pkg.sv -----
// Package for the work-stealing job dispatcher.
// Holds the command codes, the fixed field widths and the result info struct.
// No dependencies.
package wsjd_pkg;

    localparam int JOB_W    = 16;
    localparam int WORKER_W = 3;
    localparam int SRC_W    = 3;
    localparam int TOTAL_W  = 8;
    localparam int WC_W     = 4;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_TAKE   = 1'b1;

    localparam logic [WC_W-1:0]    WC_RESET  = 4'd8;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = 8'hFF;

    // Everything about one request's outcome except the popped handle,
    // which arrives later from the job store.
    typedef struct packed {
        logic               granted;
        logic               popped;
        logic [SRC_W-1:0]   source_queue;
        logic               stolen;
        logic               overflow;
        logic [TOTAL_W-1:0] queued_total;
    } t_grant_info;

endpackage

// ----- hw/rtl/wsjd_req_if.sv -----
// Request channel of the job dispatcher: valid/ready plus request payload.
// Depends on wsjd_pkg for the field widths.
interface wsjd_req_if import wsjd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [JOB_W-1:0]    job_handle;
    logic [WORKER_W-1:0] worker;

    modport source (output valid, cmd, job_handle, worker, input ready);
    modport sink   (input valid, cmd, job_handle, worker, output ready);
endinterface

// ----- hw/rtl/wsjd_res_if.sv -----
// Result channel of the job dispatcher: valid/ready plus result payload.
// Depends on wsjd_pkg for the field widths.
interface wsjd_res_if import wsjd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               granted;
    logic [JOB_W-1:0]   job_out;
    logic [SRC_W-1:0]   source_queue;
    logic               stolen;
    logic               overflow;
    logic [TOTAL_W-1:0] queued_total;

    modport source (output valid, granted, job_out, source_queue, stolen, overflow,
                    queued_total, input ready);
    modport sink   (input valid, granted, job_out, source_queue, stolen, overflow,
                    queued_total, output ready);
endinterface

// ----- hw/rtl/wsjd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wsjd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/wsjd_ctrl.sv -----
// Queue bookkeeping for the job dispatcher: per-queue head and count, the
// round-robin pointer, the steal search and the store addresses.
// Depends on wsjd_pkg; drives the job store in wsjd_ram.
module wsjd_ctrl import wsjd_pkg::*; #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16,
    localparam int AW         = $clog2(NUM_QUEUES * QUEUE_DEPTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [WC_W-1:0]        i_cfg_wdata,
    input  logic                   i_accept,
    input  logic                   i_cmd,
    input  logic [JOB_W-1:0]       i_job_handle,
    input  logic [WORKER_W-1:0]    i_worker,
    output logic                   o_ram_we,
    output logic [AW-1:0]          o_ram_waddr,
    output logic [HANDLE_BITS-1:0] o_ram_wdata,
    output logic                   o_ram_re,
    output logic [AW-1:0]          o_ram_raddr,
    output t_grant_info            o_info
);

    localparam int QW      = $clog2(NUM_QUEUES);
    localparam int CW      = $clog2(NUM_QUEUES + 1);
    localparam int HW      = $clog2(QUEUE_DEPTH);
    localparam int DW      = $clog2(QUEUE_DEPTH + 1);
    localparam int TW      = $clog2(NUM_QUEUES * QUEUE_DEPTH + 1);
    localparam int RESET_N = (8 < NUM_QUEUES) ? 8 : NUM_QUEUES;

    logic [HW-1:0]         r_head  [NUM_QUEUES];
    logic [HW-1:0]         n_head  [NUM_QUEUES];
    logic [DW-1:0]         r_count [NUM_QUEUES];
    logic [DW-1:0]         n_count [NUM_QUEUES];
    logic [QW-1:0]         r_next;
    logic [QW-1:0]         n_next;
    logic [TW-1:0]         r_total;
    logic [TW-1:0]         n_total;
    logic [CW-1:0]         r_active_n;
    logic [NUM_QUEUES-1:0] r_active_mask;
    logic [CW-1:0]         cfg_n;
    logic [NUM_QUEUES-1:0] cfg_mask;
    logic [NUM_QUEUES-1:0] rst_mask;
    t_grant_info           r_info;
    t_grant_info           n_info;

    logic [NUM_QUEUES-1:0] nonempty;
    logic [NUM_QUEUES-1:0] steal_mask;
    logic [NUM_QUEUES-1:0] steal_low;
    logic [QW-1:0]         steal_idx;
    logic                  steal_hit;
    logic                  own_ok;
    logic [QW-1:0]         own_idx;
    logic                  own_hit;
    logic                  is_submit;
    logic [QW-1:0]         tgt;
    logic                  full;
    logic                  push_ok;
    logic [DW:0]           tail_sum;
    logic [HW-1:0]         tail_pos;
    logic                  do_pop;
    logic [QW-1:0]         pq;
    logic [HW-1:0]         pop_head_nx;

    // Clamp the written worker count into 1..NUM_QUEUES once, at the write.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_n = CW'(1);
        end else if (32'(i_cfg_wdata) > NUM_QUEUES) begin
            cfg_n = CW'(NUM_QUEUES);
        end else begin
            cfg_n = CW'(i_cfg_wdata);
        end
        for (int i = 0; i < NUM_QUEUES; i++) begin
            cfg_mask[i] = (32'(cfg_n) > i);
            rst_mask[i] = (RESET_N > i);
        end
    end

    always_comb begin
        is_submit = (i_cmd == CMD_SUBMIT);
        own_ok    = (32'(i_worker) < NUM_QUEUES);
        own_idx   = QW'(i_worker);
        for (int i = 0; i < NUM_QUEUES; i++) begin
            nonempty[i]   = (r_count[i] != '0);
            steal_mask[i] = nonempty[i] && r_active_mask[i] && (32'(i_worker) != i);
        end
        own_hit   = own_ok && nonempty[own_idx];
        steal_hit = |steal_mask;
        // Isolate the lowest set bit, then turn that one-hot into an index.
        steal_low = steal_mask & (~steal_mask + 1'b1);
        steal_idx = '0;
        for (int i = 0; i < NUM_QUEUES; i++) begin
            steal_idx = steal_idx | (steal_low[i] ? QW'(i) : '0);
        end

        // A pointer left stale by a lowered count restarts at queue 0.
        tgt      = r_active_mask[r_next] ? r_next : '0;
        full     = (r_count[tgt] == DW'(QUEUE_DEPTH));
        push_ok  = is_submit && !full;
        tail_sum = (DW+1)'(r_head[tgt]) + (DW+1)'(r_count[tgt]);
        tail_pos = (tail_sum >= (DW+1)'(QUEUE_DEPTH)) ?
                   HW'(tail_sum - (DW+1)'(QUEUE_DEPTH)) : HW'(tail_sum);

        do_pop      = !is_submit && (own_hit || steal_hit);
        pq          = own_hit ? own_idx : steal_idx;
        pop_head_nx = (32'(r_head[pq]) + 1 == QUEUE_DEPTH) ? '0 : HW'(r_head[pq] + 1'b1);

        n_head  = r_head;
        n_count = r_count;
        n_next  = r_next;
        n_total = r_total;
        if (i_accept) begin
            if (is_submit) begin
                n_next = ((CW'(tgt) + 1'b1) == r_active_n) ? '0 : QW'(tgt + 1'b1);
                if (push_ok) begin
                    n_count[tgt] = r_count[tgt] + 1'b1;
                    n_total      = r_total + 1'b1;
                end
            end else if (do_pop) begin
                n_head[pq]  = pop_head_nx;
                n_count[pq] = r_count[pq] - 1'b1;
                n_total     = r_total - 1'b1;
            end
        end

        n_info.granted      = push_ok || do_pop;
        n_info.popped       = do_pop;
        n_info.source_queue = is_submit ? SRC_W'(tgt) : (do_pop ? SRC_W'(pq) : '0);
        n_info.stolen       = do_pop && !own_hit;
        n_info.overflow     = is_submit && full;
        n_info.queued_total = (32'(n_total) > 32'(TOTAL_SAT)) ? TOTAL_SAT
                                                              : TOTAL_W'(n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
            r_next        <= '0;
            r_total       <= '0;
            r_active_n    <= CW'(RESET_N);
            r_active_mask <= rst_mask;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_next  <= n_next;
            r_total <= n_total;
            if (i_cfg_we) begin
                r_active_n    <= cfg_n;
                r_active_mask <= cfg_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_info <= n_info;
        end
    end

    assign o_info      = r_info;
    assign o_ram_we    = i_accept && push_ok;
    assign o_ram_waddr = AW'(tgt) * AW'(QUEUE_DEPTH) + AW'(tail_pos);
    assign o_ram_wdata = HANDLE_BITS'(i_job_handle);
    assign o_ram_re    = i_accept && do_pop;
    assign o_ram_raddr = AW'(pq) * AW'(QUEUE_DEPTH) + AW'(r_head[pq]);

    // The running total only moves when a request is taken in.
    a_total_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_total))
        else $error("queued total changed without a request");

    // A granted take leaves exactly one job fewer in the queues.
    a_take_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !is_submit && do_pop |=> r_total == $past(r_total) - 1'b1)
        else $error("granted take did not remove one job");

    // After a submit the round-robin pointer names an active queue.
    a_next_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && is_submit && !i_cfg_we |=> r_active_mask[r_next])
        else $error("round-robin pointer left the active queues");

    // A steal is only made when the asking worker's own queue was empty.
    a_steal_own_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && do_pop && !own_hit |-> !(own_ok && nonempty[own_idx]))
        else $error("steal taken while own queue held jobs");

endmodule

// ----- hw/rtl/work_stealing_job_dispatcher_core.sv -----
// Top level of the work-stealing job dispatcher: request intake, the
// bookkeeping unit, the job store and the result register.
// Depends on wsjd_pkg, wsjd_req_if, wsjd_res_if, wsjd_ctrl and wsjd_ram.
//
//  channel      direction  handshake          payload
//  i_req        in         valid / ready      cmd, job_handle, worker
//  o_res        out        valid / ready      granted, job_out, source_queue,
//                                             stolen, overflow, queued_total
//  i_cfg_*      in         i_cfg_we           i_cfg_wdata (worker count)
//
// One request is taken per clock unless the result side stalls; its result
// is registered in stage one (bookkeeping and store read) and then in the
// output register. The job store does at most one push or one pop per cycle.
// Synchronous reset empties all queues at once; there is no clearing pass.
// A stalled result holds in the output register while one more request
// completes in the stage behind it, then the request side stalls.
module work_stealing_job_dispatcher_core import wsjd_pkg::*; #(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WC_W-1:0]  i_cfg_wdata,
    wsjd_req_if.sink         i_req,
    wsjd_res_if.source       o_res
);

    localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);

    logic                   accept;
    logic                   s1_move;
    logic                   r_s1_valid;
    logic                   r_out_valid;
    t_grant_info            r_out_info;
    logic [JOB_W-1:0]       r_out_job;
    t_grant_info            s1_info;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [HANDLE_BITS-1:0] ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [HANDLE_BITS-1:0] ram_rdata;

    // The store's read register holds while stage one waits, since no new
    // request is taken then.
    assign s1_move     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_s1_valid || s1_move;
    assign accept      = i_req.valid && i_req.ready;

    wsjd_ctrl #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept),
        .i_cmd        (i_req.cmd),
        .i_job_handle (i_req.job_handle),
        .i_worker     (i_req.worker),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .o_info       (s1_info)
    );

    wsjd_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_info <= s1_info;
            r_out_job  <= s1_info.popped ? JOB_W'(ram_rdata) : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.granted      = r_out_info.granted;
    assign o_res.job_out      = r_out_job;
    assign o_res.source_queue = r_out_info.source_queue;
    assign o_res.stolen       = r_out_info.stolen;
    assign o_res.overflow     = r_out_info.overflow;
    assign o_res.queued_total = r_out_info.queued_total;

endmodule

// ----- sim/work_stealing_job_dispatcher_core_tb.sv -----
// Self-checking testbench for work_stealing_job_dispatcher_core.
// A ledger class predicts each result from its own copy of the queues.
// Depends on wsjd_pkg, wsjd_req_if, wsjd_res_if and the dispatcher RTL.
`timescale 1ns / 1ps

module work_stealing_job_dispatcher_core_tb;
    import wsjd_pkg::*;

    localparam int NQ               = 8;
    localparam int DEPTH            = 16;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES     = 4;

    typedef struct packed {
        logic               granted;
        logic [JOB_W-1:0]   job_out;
        logic [SRC_W-1:0]   source_queue;
        logic               stolen;
        logic               overflow;
        logic [TOTAL_W-1:0] queued_total;
    } t_dispatch_result;

    // Tracks the contents of every worker queue and the results they imply.
    class t_dispatch_ledger;
        logic [JOB_W-1:0] job_slots [NQ][DEPTH];
        logic [3:0]       head [NQ];
        logic [4:0]       fill [NQ];
        logic [2:0]       rr_ptr;
        logic [WC_W-1:0]  worker_count;
        t_dispatch_result awaited_results[$];
        int mismatches, n_submit, n_dropped, n_take, n_stolen, n_empty, n_configs;

        function new();
            for (int q = 0; q < NQ; q++) begin
                head[q] = '0;
                fill[q] = '0;
            end
            rr_ptr       = '0;
            worker_count = WC_RESET;
            mismatches   = 0;
            n_submit     = 0;
            n_dropped    = 0;
            n_take       = 0;
            n_stolen     = 0;
            n_empty      = 0;
            n_configs    = 0;
        endfunction

        function void set_worker_count(logic [WC_W-1:0] value);
            worker_count = value;
            n_configs++;
        endfunction

        // Zero behaves as one queue and anything above the queue count as all queues.
        function int unsigned active_queues();
            if (worker_count == 0) return 1;
            if (worker_count > NQ) return NQ;
            return worker_count;
        endfunction

        function logic [JOB_W-1:0] pop_job(int unsigned q);
            logic [JOB_W-1:0] job;
            job = job_slots[q][head[q]];
            head[q] = head[q] + 4'd1;
            fill[q] = fill[q] - 5'd1;
            return job;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void record_request(logic cmd, logic [JOB_W-1:0] handle,
                                     logic [WORKER_W-1:0] worker);
            t_dispatch_result r;
            int unsigned n, q, total;
            logic [3:0] slot;
            bit found;
            n = active_queues();
            r = '0;
            if (cmd == CMD_SUBMIT) begin
                n_submit++;
                // A pointer left beyond a lowered count restarts at queue 0.
                q = (rr_ptr < n) ? rr_ptr : 0;
                r.source_queue = q[SRC_W-1:0];
                if (fill[q] >= DEPTH) begin
                    r.overflow = 1'b1;
                    n_dropped++;
                end else begin
                    slot = head[q] + fill[q][3:0];
                    job_slots[q][slot] = handle;
                    fill[q] = fill[q] + 5'd1;
                    r.granted = 1'b1;
                end
                rr_ptr = (q + 1 >= n) ? 3'd0 : 3'(q + 1);
            end else begin
                n_take++;
                // The worker's own queue is tried even outside the active set.
                if (fill[worker] != 0) begin
                    r.job_out      = pop_job(worker);
                    r.source_queue = worker;
                    r.granted      = 1'b1;
                end else begin
                    found = 1'b0;
                    for (int i = 0; i < n; i++) begin
                        if (!found && i != worker && fill[i] != 0) begin
                            found          = 1'b1;
                            r.job_out      = pop_job(i);
                            r.source_queue = i[SRC_W-1:0];
                            r.granted      = 1'b1;
                            r.stolen       = 1'b1;
                        end
                    end
                    if (found) n_stolen++;
                    else n_empty++;
                end
            end
            total = 0;
            for (int i = 0; i < NQ; i++) total += fill[i];
            r.queued_total = (total > 255) ? TOTAL_SAT : total[TOTAL_W-1:0];
            awaited_results = {awaited_results, r};
        endfunction

        function void compare_field(string name, logic [JOB_W-1:0] want,
                                    logic [JOB_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_dispatch_result got);
            t_dispatch_result want;
            if (awaited_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = awaited_results[0];
            awaited_results.delete(0);
            compare_field("granted", want.granted, got.granted);
            compare_field("job_out", want.job_out, got.job_out);
            compare_field("source_queue", want.source_queue, got.source_queue);
            compare_field("stolen", want.stolen, got.stolen);
            compare_field("overflow", want.overflow, got.overflow);
            compare_field("queued_total", want.queued_total, got.queued_total);
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [WC_W-1:0] i_cfg_wdata;

    wsjd_req_if req_ch ();
    wsjd_res_if res_ch ();

    work_stealing_job_dispatcher_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    t_dispatch_ledger ledger = new();
    bit rst_done          = 1'b0;
    bit gaps_on           = 1'b1;
    bit long_hold_pending = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(input logic cmd, input logic [JOB_W-1:0] handle,
                                input logic [WORKER_W-1:0] worker);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.job_handle <= handle;
        req_ch.worker     <= worker;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        ledger.record_request(cmd, handle, worker);
    endtask

    task automatic submit(input logic [JOB_W-1:0] handle);
        send_request(CMD_SUBMIT, handle, WORKER_W'($urandom_range(0, 7)));
    endtask

    task automatic take(input logic [WORKER_W-1:0] worker);
        send_request(CMD_TAKE, JOB_W'($urandom_range(0, 65535)), worker);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_worker_count(input logic [WC_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ledger.set_worker_count(value);
    endtask

    task automatic run_phase(input logic [WC_W-1:0] count, input int submit_pct,
                             input int n_items, input bit hold_output, input bit pause_mid);
        logic [JOB_W-1:0] h;
        write_worker_count(count);
        for (int k = 0; k < n_items; k++) begin
            if (hold_output && k == 5) long_hold_pending = 1'b1;
            if (pause_mid && k == n_items / 2) wait_drained();
            case ($urandom_range(0, 9))
                0:       h = '0;
                1:       h = '1;
                default: h = JOB_W'($urandom_range(0, 65535));
            endcase
            if ($urandom_range(1, 100) <= submit_pct)
                send_request(CMD_SUBMIT, h, WORKER_W'($urandom_range(0, 7)));
            else
                send_request(CMD_TAKE, h, WORKER_W'($urandom_range(0, 7)));
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        wait (rst_done);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                ledger.check_result('{res_ch.granted, res_ch.job_out, res_ch.source_queue,
                                      res_ch.stolen, res_ch.overflow, res_ch.queued_total});
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Ends a hung run with a FAIL message.
    initial begin : watchdog
        #400000;
        $display("FAIL work_stealing_job_dispatcher_core");
        $finish;
    end

    initial begin : stimulus
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_SUBMIT;
        req_ch.job_handle <= '0;
        req_ch.worker     <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_rst_n           <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1'b1;
        @(posedge i_clk);

        // All eight queues active: empty take, handle extremes, own pop and steals.
        take(3'd7);
        submit(16'hFFFF);
        submit(16'h0000);
        submit(16'hA5A5);
        submit(16'h5A5A);
        submit(16'h1234);
        submit(16'h8001);
        take(3'd0);
        take(3'd0);
        take(3'd6);
        take(3'd5);

        // Lowering the count leaves a stale pointer and strands queues 3 and 4.
        write_worker_count(4'd2);
        submit(16'h00FF);
        submit(16'hFF00);
        take(3'd7);
        take(3'd4);
        take(3'd3);
        take(3'd3);
        take(3'd0);

        // A count of zero behaves as a single queue.
        write_worker_count(4'd0);
        submit(16'h7FFF);
        take(3'd5);
        take(3'd0);

        run_phase(4'd1, 85, 50, 1'b0, 1'b0);
        run_phase(4'd15, 50, 50, 1'b1, 1'b0);
        run_phase(4'd5, 75, 50, 1'b0, 1'b0);
        run_phase(4'd3, 30, 50, 1'b0, 1'b1);
        run_phase(4'd9, 60, 50, 1'b0, 1'b0);
        run_phase(4'd2, 90, 50, 1'b0, 1'b0);
        run_phase(4'd7, 40, 50, 1'b0, 1'b0);
        run_phase(4'd4, 50, 50, 1'b0, 1'b0);
        run_phase(4'd8, 20, 50, 1'b0, 1'b0);
        gaps_on = 1'b0;
        run_phase(4'd6, 50, 50, 1'b0, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d submits (%0d dropped) and %0d takes (%0d stolen, %0d empty).",
                 ledger.n_submit, ledger.n_dropped, ledger.n_take, ledger.n_stolen,
                 ledger.n_empty);
        $display("Worker count was set %0d times; a long output stall and a full drain ran.",
                 ledger.n_configs);
        if (ledger.mismatches == 0)
            $display("PASS work_stealing_job_dispatcher_core");
        else
            $display("FAIL work_stealing_job_dispatcher_core");
        $finish;
    end

endmodule

// ----- work_stealing_job_dispatcher_core.f -----
hw/rtl/wsjd_pkg.sv
hw/rtl/wsjd_req_if.sv
hw/rtl/wsjd_res_if.sv
hw/rtl/wsjd_ram.sv
hw/rtl/wsjd_ctrl.sv
hw/rtl/work_stealing_job_dispatcher_core.sv
sim/work_stealing_job_dispatcher_core_tb.sv
